// File: hdl/asbs_pkg.sv
// ----------------------------------------------------------------------------
// asbs_pkg
// Shared types and constants for the alarm servo and buzzer sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package asbs_pkg;

  // Alarm phase codes
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ACTIVE = 2'd1,
    PH_COOL   = 2'd2
  } phase_t;

  // Input action codes
  localparam logic ACT_PROCESS  = 1'b0;
  localparam logic ACT_ACTIVATE = 1'b1;

  // Register indexes (byte address = 4 * index)
  localparam int unsigned RegIdxW = 3;
  localparam logic [RegIdxW-1:0] REG_DURATION = 3'd0;
  localparam logic [RegIdxW-1:0] REG_COOLDOWN = 3'd1;
  localparam logic [RegIdxW-1:0] REG_SWEEP    = 3'd2;
  localparam logic [RegIdxW-1:0] REG_TOGGLE   = 3'd3;
  localparam logic [RegIdxW-1:0] REG_BEEPS    = 3'd4;
  localparam logic [RegIdxW-1:0] REG_MIN      = 3'd5;
  localparam logic [RegIdxW-1:0] REG_MAX      = 3'd6;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // Register reset values
  localparam logic [23:0] DURATION_RST = 24'd10000;
  localparam logic [15:0] COOLDOWN_RST = 16'd2000;
  localparam logic [15:0] SWEEP_RST    = 16'd500;
  localparam logic [15:0] TOGGLE_RST   = 16'd200;
  localparam logic [6:0]  BEEPS_RST    = 7'd3;
  localparam logic [14:0] MIN_RST      = 15'd1000;
  localparam logic [14:0] MAX_RST      = 15'd2000;

  localparam logic [9:0]  BUZZER_ON_LEVEL = 10'd500;

  typedef struct packed {
    logic        action;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [14:0] servo_pulse_us;
    logic [9:0]  buzzer_level;
    logic        is_active;
    logic [1:0]  phase;
  } out_t;

endpackage

`default_nettype wire

// File: hdl/alarm_servo_buzzer_sequencer_top.sv
// ----------------------------------------------------------------------------
// alarm_servo_buzzer_sequencer_top
// Timed alarm: servo sweep, buzzer bursts, cool-down, APB register port.
// ----------------------------------------------------------------------------
// The result is registered on out_data. Throughput: one transfer per cycle
// while in_stall is low; the phase and timer registers update at the
// accepting edge, so each event sees the state left by the previous one.
// A skid register behind the result register lets one more event in while the
// result is stalled; in_stall is raised only when the skid register is full.
// Reset (rst, synchronous, active high): idle phase, registers to defaults.
`timescale 1ns / 1ps
`default_nettype none

module alarm_servo_buzzer_sequencer_top (
  input  wire                        clk,
  input  wire                        rst,
  // input channel
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire asbs_pkg::in_t         in_data,
  // result channel
  output logic                       out_valid,
  input  wire                        out_stall,
  output asbs_pkg::out_t             out_data,
  // APB register port
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire [asbs_pkg::AddrW-1:0]  paddr,
  input  wire [asbs_pkg::DataW-1:0]  pwdata,
  output logic [asbs_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import asbs_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [23:0] active_len_ms;
  logic [15:0] cooldown_ms;
  logic [15:0] servo_sweep_period_ms;
  logic [15:0] buzzer_toggle_period_ms;
  logic [6:0]  beeps_per_burst;
  logic [14:0] servo_min_pulse_us;
  logic [14:0] servo_max_pulse_us;

  logic               cfg_wr;
  logic [RegIdxW-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  // word index; byte lane bits are ignored
  assign cfg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      active_len_ms           <= DURATION_RST;
      cooldown_ms             <= COOLDOWN_RST;
      servo_sweep_period_ms   <= SWEEP_RST;
      buzzer_toggle_period_ms <= TOGGLE_RST;
      beeps_per_burst         <= BEEPS_RST;
      servo_min_pulse_us      <= MIN_RST;
      servo_max_pulse_us      <= MAX_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DURATION: active_len_ms           <= pwdata[23:0];
        REG_COOLDOWN: cooldown_ms             <= pwdata[15:0];
        REG_SWEEP:    servo_sweep_period_ms   <= pwdata[15:0];
        REG_TOGGLE:   buzzer_toggle_period_ms <= pwdata[15:0];
        REG_BEEPS:    beeps_per_burst         <= pwdata[6:0];
        REG_MIN:      servo_min_pulse_us      <= pwdata[14:0];
        REG_MAX:      servo_max_pulse_us      <= pwdata[14:0];
        default: ;  // unmapped word, write dropped
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (cfg_idx)
      REG_DURATION: prdata = {8'd0, active_len_ms};
      REG_COOLDOWN: prdata = {16'd0, cooldown_ms};
      REG_SWEEP:    prdata = {16'd0, servo_sweep_period_ms};
      REG_TOGGLE:   prdata = {16'd0, buzzer_toggle_period_ms};
      REG_BEEPS:    prdata = {25'd0, beeps_per_burst};
      REG_MIN:      prdata = {17'd0, servo_min_pulse_us};
      REG_MAX:      prdata = {17'd0, servo_max_pulse_us};
      default:      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: result register plus one skid entry
  // --------------------------------------------------------------------------
  logic in_fire;
  logic out_fire;
  logic skid_valid;
  out_t skid_data;
  out_t res;

  assign in_stall = skid_valid;
  assign in_fire  = in_valid & ~in_stall;
  assign out_fire = out_valid & ~out_stall;

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  phase_t      alarm_phase,      alarm_phase_next;
  logic [31:0] start_time,       start_time_next;
  logic [31:0] last_sweep_time,  last_sweep_time_next;
  logic [31:0] last_toggle_time, last_toggle_time_next;
  logic        servo_at_max,     servo_at_max_next;
  logic [7:0]  toggle_count,     toggle_count_next;
  logic        buzzer_is_on,     buzzer_is_on_next;
  logic [14:0] held_servo_pulse, held_servo_pulse_next;

  // elapsed times, wrapping 32-bit
  logic [31:0] since_start;
  logic [31:0] since_sweep;
  logic [31:0] since_toggle;
  logic [24:0] cool_end;      // duration + cooldown, no wrap
  logic [15:0] pulse_sum;
  logic [14:0] mid_pulse;
  logic [7:0]  toggle_limit;

  assign since_start  = in_data.now_ms - start_time;
  assign since_sweep  = in_data.now_ms - last_sweep_time;
  assign since_toggle = in_data.now_ms - last_toggle_time;
  assign cool_end     = {1'b0, active_len_ms} + {9'd0, cooldown_ms};
  assign pulse_sum    = {1'b0, servo_min_pulse_us} + {1'b0, servo_max_pulse_us};
  assign mid_pulse    = pulse_sum[15:1];
  assign toggle_limit = {beeps_per_burst, 1'b0};

  always_comb begin
    alarm_phase_next      = alarm_phase;
    start_time_next       = start_time;
    last_sweep_time_next  = last_sweep_time;
    last_toggle_time_next = last_toggle_time;
    servo_at_max_next     = servo_at_max;
    toggle_count_next     = toggle_count;
    buzzer_is_on_next     = buzzer_is_on;
    held_servo_pulse_next = held_servo_pulse;

    if (in_data.action == ACT_ACTIVATE) begin
      // only idle (or the unused code) arms the alarm
      if (alarm_phase != PH_ACTIVE && alarm_phase != PH_COOL) begin
        alarm_phase_next      = PH_ACTIVE;
        start_time_next       = in_data.now_ms;
        last_sweep_time_next  = in_data.now_ms;
        last_toggle_time_next = in_data.now_ms;
        servo_at_max_next     = 1'b0;
        toggle_count_next     = 8'd0;
        held_servo_pulse_next = servo_min_pulse_us;
        buzzer_is_on_next     = 1'b1;
      end
    end else begin
      unique case (alarm_phase)
        PH_ACTIVE: begin
          if (since_start > {8'd0, active_len_ms}) begin
            alarm_phase_next      = PH_COOL;
            held_servo_pulse_next = mid_pulse;
          end else begin
            if (since_sweep > {16'd0, servo_sweep_period_ms}) begin
              held_servo_pulse_next = servo_at_max ? servo_min_pulse_us
                                                   : servo_max_pulse_us;
              servo_at_max_next     = ~servo_at_max;
              last_sweep_time_next  = in_data.now_ms;
            end
            if (since_toggle > {16'd0, buzzer_toggle_period_ms}) begin
              if (toggle_count < toggle_limit) begin
                buzzer_is_on_next = ~buzzer_is_on;
                toggle_count_next = toggle_count + 8'd1;
              end else begin
                toggle_count_next = 8'd0;  // quiet period, burst restarts
              end
              last_toggle_time_next = in_data.now_ms;
            end
          end
        end
        PH_COOL: begin
          if (since_start > {7'd0, cool_end}) begin
            alarm_phase_next = PH_IDLE;
          end
        end
        default: ;  // idle: nothing to do
      endcase
    end

    res.servo_pulse_us = held_servo_pulse_next;
    res.buzzer_level   = (alarm_phase_next == PH_ACTIVE && buzzer_is_on_next)
                         ? BUZZER_ON_LEVEL : 10'd0;
    res.is_active      = (alarm_phase_next == PH_ACTIVE);
    res.phase          = alarm_phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_phase      <= PH_IDLE;
      start_time       <= '0;
      last_sweep_time  <= '0;
      last_toggle_time <= '0;
      servo_at_max     <= 1'b0;
      toggle_count     <= '0;
      buzzer_is_on     <= 1'b0;
      held_servo_pulse <= MIN_RST;
    end else if (in_fire) begin
      alarm_phase      <= alarm_phase_next;
      start_time       <= start_time_next;
      last_sweep_time  <= last_sweep_time_next;
      last_toggle_time <= last_toggle_time_next;
      servo_at_max     <= servo_at_max_next;
      toggle_count     <= toggle_count_next;
      buzzer_is_on     <= buzzer_is_on_next;
      held_servo_pulse <= held_servo_pulse_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register and skid entry
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_fire || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;  // result held, park the new one
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_fire) begin
        out_data <= res;
      end
    end else if (in_fire) begin
      skid_data <= res;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry full with empty result register");

  a_skid_drains : assert property (@(posedge clk) disable iff (rst)
    (out_fire && skid_valid) |=> (!skid_valid && out_valid))
    else $error("skid entry not moved on transfer");

  a_active_flag : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.is_active == (out_data.phase == PH_ACTIVE)))
    else $error("active flag disagrees with phase");

  a_buzzer_only_active : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.buzzer_level != 10'd0) |-> out_data.is_active)
    else $error("buzzer on outside active phase");

  a_reset_idle : assert property (@(posedge clk)
    $past(rst) |-> (alarm_phase == PH_IDLE && !out_valid && !skid_valid))
    else $error("state not cleared by reset");

endmodule

`default_nettype wire

// File: tb/asbs_tb_pkg.sv
// ----------------------------------------------------------------------------
// asbs_tb_pkg
// Alarm sequence tracker: predicts the sequencer's result for every transfer
// in, queues it and checks transfers out against it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asbs_tb_pkg;

  import asbs_pkg::*;

  class alarm_tracker;

    // register copies
    logic [23:0] duration;
    logic [15:0] cooldown;
    logic [15:0] sweep_period;
    logic [15:0] toggle_period;
    logic [6:0]  beeps;
    logic [14:0] min_pulse;
    logic [14:0] max_pulse;

    // sequencer state
    phase_t      ph;
    logic [31:0] start_ms;
    logic [31:0] sweep_ms;
    logic [31:0] toggle_ms;
    bit          at_max;
    logic [7:0]  toggles;
    bit          buzz_on;
    logic [14:0] held;

    out_t        due_levels[$];

    int unsigned mismatches;
    int unsigned events_in;
    int unsigned results_seen;
    int unsigned started;
    int unsigned cooled;
    int unsigned idled;
    int unsigned moves;
    int unsigned flips;
    int unsigned skips;

    function new();
      duration      = DURATION_RST;
      cooldown      = COOLDOWN_RST;
      sweep_period  = SWEEP_RST;
      toggle_period = TOGGLE_RST;
      beeps         = BEEPS_RST;
      min_pulse     = MIN_RST;
      max_pulse     = MAX_RST;
      ph        = PH_IDLE;
      start_ms  = '0;
      sweep_ms  = '0;
      toggle_ms = '0;
      at_max    = 1'b0;
      toggles   = '0;
      buzz_on   = 1'b0;
      held      = MIN_RST;
    endfunction

    function void set_reg(logic [RegIdxW-1:0] idx, logic [31:0] value);
      case (idx)
        REG_DURATION: duration      = value[23:0];
        REG_COOLDOWN: cooldown      = value[15:0];
        REG_SWEEP:    sweep_period  = value[15:0];
        REG_TOGGLE:   toggle_period = value[15:0];
        REG_BEEPS:    beeps         = value[6:0];
        REG_MIN:      min_pulse     = value[14:0];
        REG_MAX:      max_pulse     = value[14:0];
        default: ;
      endcase
    endfunction

    function void report_mismatch(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endfunction

    // One step of the sequencer; returns the levels it leaves on the outputs.
    function out_t advance_alarm(in_t item);
      logic [31:0] t;
      logic [31:0] since_start;
      logic [31:0] end_of_cool;
      logic [15:0] pulse_sum;
      out_t        lv;
      t           = item.now_ms;
      since_start = t - start_ms;
      end_of_cool = {8'd0, duration} + {16'd0, cooldown};
      pulse_sum   = {1'b0, min_pulse} + {1'b0, max_pulse};
      if (item.action == ACT_ACTIVATE) begin
        if (ph != PH_ACTIVE && ph != PH_COOL) begin
          ph        = PH_ACTIVE;
          start_ms  = t;
          sweep_ms  = t;
          toggle_ms = t;
          at_max    = 1'b0;
          toggles   = '0;
          held      = min_pulse;
          buzz_on   = 1'b1;
          started++;
        end
      end else if (ph == PH_ACTIVE) begin
        if (since_start > {8'd0, duration}) begin
          ph   = PH_COOL;
          held = pulse_sum[15:1];
          cooled++;
        end else begin
          if (t - sweep_ms > {16'd0, sweep_period}) begin
            held     = at_max ? min_pulse : max_pulse;
            at_max   = !at_max;
            sweep_ms = t;
            moves++;
          end
          if (t - toggle_ms > {16'd0, toggle_period}) begin
            if (toggles < {beeps, 1'b0}) begin
              buzz_on = !buzz_on;
              toggles = toggles + 8'd1;
              flips++;
            end else begin
              toggles = '0;
              skips++;
            end
            toggle_ms = t;
          end
        end
      end else if (ph == PH_COOL) begin
        if (since_start > end_of_cool) begin
          ph = PH_IDLE;
          idled++;
        end
      end
      lv.servo_pulse_us = held;
      lv.buzzer_level   = (ph == PH_ACTIVE && buzz_on) ? BUZZER_ON_LEVEL : 10'd0;
      lv.is_active      = (ph == PH_ACTIVE);
      lv.phase          = ph;
      return lv;
    endfunction

    function void note_event(in_t item);
      events_in++;
      due_levels.push_back(advance_alarm(item));
    endfunction

    function void check_levels(out_t got);
      out_t want;
      results_seen++;
      if (due_levels.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing due", results_seen));
        return;
      end
      want = due_levels.pop_front();
      if (got.servo_pulse_us !== want.servo_pulse_us)
        report_mismatch($sformatf("result %0d servo pulse %0d, want %0d",
                                  results_seen, got.servo_pulse_us, want.servo_pulse_us));
      if (got.buzzer_level !== want.buzzer_level)
        report_mismatch($sformatf("result %0d buzzer level %0d, want %0d",
                                  results_seen, got.buzzer_level, want.buzzer_level));
      if (got.is_active !== want.is_active)
        report_mismatch($sformatf("result %0d alarm active %b, want %b",
                                  results_seen, got.is_active, want.is_active));
      if (got.phase !== want.phase)
        report_mismatch($sformatf("result %0d phase %0d, want %0d",
                                  results_seen, got.phase, want.phase));
    endfunction

  endclass

endpackage

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the alarm servo and buzzer sequencer: directed
// boundary items, then random alarm sequences across several register
// settings, with random idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  import asbs_pkg::*;
  import asbs_tb_pkg::*;

  // generous: well above what the slowest correct run needs
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SETTINGS_N  = 8;
  localparam int unsigned PER_SETTING = 125;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic        pready;

  alarm_tracker sb;

  // pacing knobs shared between the driving processes
  bit          tx_idling;
  bit          rx_idling;
  int unsigned long_hold;
  int unsigned items_sent;
  int unsigned cycle_count = 0;
  logic [31:0] now_cursor;

  alarm_servo_buzzer_sequencer_top dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, sb.due_levels.size());
      $display("status: fail");
      $finish;
    end
  end

  // Monitor. All inputs are driven by nonblocking assignment, so the values
  // read here are the ones the block saw at this edge. A transfer in is
  // noted before the result check; the result register keeps them apart.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_event(in_data);
      if (out_valid && !out_stall) sb.check_levels(out_data);
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request so that
  // the result and skid registers fill and the block stalls its input.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold != 0) begin
        out_stall <= 1'b1;
        repeat (long_hold) @(posedge clk);
        long_hold = 0;
        out_stall <= 1'b0;
      end else if (rx_idling && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one item; returns just after the edge at which it was taken.
  // Each signal gets one nonblocking assignment per time step.
  task automatic offer(input logic act, input logic [31:0] stamp);
    if (tx_idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= in_t'{act, stamp};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Sender pause: nothing offered until every due result has come back.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write (setup + access), bus idle, then a read-back check.
  task automatic program_reg(input logic [RegIdxW-1:0] idx, input logic [31:0] value);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== value)
      sb.report_mismatch($sformatf("register %0d reads %0d, wrote %0d", idx, got, value));
  endtask

  // Registers for one phase of the run: all zero, all at the top but max at
  // zero, small values that keep alarms short and busy, or a per-field mix.
  task automatic program_setting(input int unsigned setting);
    logic [RegIdxW-1:0] regs[7]      = '{REG_DURATION, REG_COOLDOWN, REG_SWEEP, REG_TOGGLE,
                                         REG_BEEPS, REG_MIN, REG_MAX};
    logic [31:0]        tops[7]      = '{32'd16777215, 32'd65535, 32'd65535, 32'd65535,
                                         32'd127, 32'd19999, 32'd19999};
    logic [31:0]        small_tops[7] = '{32'd60, 32'd20, 32'd8, 32'd6,
                                          32'd4, 32'd19999, 32'd19999};
    int unsigned        mode;
    logic [31:0]        value;
    foreach (regs[r]) begin
      case (setting)
        0, SETTINGS_N - 1: mode = 2;
        1:                 mode = (regs[r] == REG_MAX) ? 0 : 1;  // max below min
        2:                 mode = 0;
        default:           mode = $urandom_range(0, 3);
      endcase
      case (mode)
        0:       value = '0;
        1:       value = tops[r];
        2:       value = $urandom_range(0, small_tops[r]);
        default: value = $urandom_range(0, tops[r]);
      endcase
      program_reg(regs[r], value);
    end
  endtask

  // A well-formed alarm: activate, a run of process events with random
  // spacing around the periods and some repeat activates, then events on and
  // just past the end of the active phase (not always) and of the cool-down.
  task automatic alarm_sequence();
    logic [31:0] t0;
    logic [31:0] span;
    logic [31:0] step_cap;
    int unsigned events;
    span     = {8'd0, sb.duration} + {16'd0, sb.cooldown} + 32'd2;
    step_cap = ((sb.sweep_period > sb.toggle_period) ? {16'd0, sb.sweep_period}
                                                      : {16'd0, sb.toggle_period}) + 32'd3;
    if ($urandom_range(0, 3) == 0) now_cursor = $urandom();
    t0 = now_cursor;
    offer(ACT_ACTIVATE, t0);
    events = $urandom_range(4, 30);
    repeat (events) begin
      case ($urandom_range(0, 9))
        0:       offer(ACT_ACTIVATE, now_cursor);  // ignored while the alarm is still running
        1:       now_cursor = now_cursor + $urandom_range(0, span / 4 + 1);
        default: now_cursor = now_cursor + $urandom_range(0, step_cap);
      endcase
      offer(ACT_PROCESS, now_cursor);
    end
    if ($urandom_range(0, 1) == 1) begin
      now_cursor = t0 + {8'd0, sb.duration} + $urandom_range(0, 1);
      offer(ACT_PROCESS, now_cursor);
    end
    now_cursor = t0 + {8'd0, sb.duration} + {16'd0, sb.cooldown} + $urandom_range(0, 2);
    offer(ACT_PROCESS, now_cursor);
    now_cursor = now_cursor + 32'd1;
    offer(ACT_PROCESS, now_cursor);
  endtask

  initial begin
    int unsigned target;
    sb = new();
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    in_data    <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    tx_idling  = 1'b1;
    rx_idling  = 1'b1;
    long_hold  = 0;
    items_sent = 0;
    now_cursor = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed: reset registers first ---
    offer(ACT_PROCESS, 32'd0);        // idle, reset pulse held
    offer(ACT_ACTIVATE, 32'd100);
    offer(ACT_PROCESS, 32'd300);      // toggle period met exactly: no toggle
    offer(ACT_PROCESS, 32'd301);      // just past it: buzzer off
    offer(ACT_PROCESS, 32'd601);      // sweep to max, buzzer back on
    wait_results_done();

    // Short timings, full pulse span. The alarm is still running, so the
    // next event ends it with the new duration and a fresh mid pulse.
    program_reg(REG_DURATION, 32'd20);
    program_reg(REG_COOLDOWN, 32'd5);
    program_reg(REG_SWEEP,    32'd3);
    program_reg(REG_TOGGLE,   32'd2);
    program_reg(REG_BEEPS,    32'd1);
    program_reg(REG_MIN,      32'd0);
    program_reg(REG_MAX,      32'd19999);
    offer(ACT_PROCESS, 32'd602);      // into cool-down
    offer(ACT_ACTIVATE, 32'd603);     // ignored while cooling
    offer(ACT_PROCESS, 32'd125);      // duration + cooldown met exactly: stays
    offer(ACT_PROCESS, 32'd126);      // back to idle
    offer(ACT_ACTIVATE, 32'hFFFF_FFFE);  // start just below the wrap
    offer(ACT_ACTIVATE, 32'd5);       // ignored while active
    offer(ACT_PROCESS, 32'd0);        // elapsed 2 across the wrap
    offer(ACT_PROCESS, 32'd1);        // toggle
    offer(ACT_PROCESS, 32'd2);        // sweep to max
    offer(ACT_PROCESS, 32'd4);        // second toggle ends the burst
    offer(ACT_PROCESS, 32'd7);        // skipped period, sweep back
    offer(ACT_PROCESS, 32'd10);
    offer(ACT_PROCESS, 32'd18);       // duration met exactly: still active
    offer(ACT_PROCESS, 32'd19);       // past it: cool-down
    offer(ACT_PROCESS, 32'hFFFF_FFFF);
    offer(ACT_PROCESS, 32'd24);       // idle again
    offer(ACT_ACTIVATE, 32'hFFFF_FFFF);
    offer(ACT_PROCESS, 32'h7FFF_FFFF);  // huge elapsed time
    wait_results_done();

    // --- random alarm sequences over several register settings ---
    for (int unsigned setting = 0; setting < SETTINGS_N; setting++) begin
      if (setting != 0) wait_results_done();
      program_setting(setting);
      tx_idling = (setting != 5) && (setting != SETTINGS_N - 1);
      rx_idling = (setting != 5) && (setting != SETTINGS_N - 1);
      if (setting == 3) long_hold = 300;
      target = items_sent + PER_SETTING;
      while (items_sent < target) begin
        if (setting == 4 && items_sent >= target - PER_SETTING / 2 && items_sent < target - 40)
          wait_results_done();
        if ($urandom_range(0, 4) != 0) begin
          alarm_sequence();
        end else begin
          repeat ($urandom_range(1, 4)) offer($urandom_range(0, 1), $urandom());
        end
      end
    end

    wait_results_done();
    $display("covered %0d transfers in and %0d results over %0d register settings",
             sb.events_in, sb.results_seen, SETTINGS_N + 2);
    $display("alarms %0d, cool-downs %0d, back to idle %0d, servo moves %0d, toggles %0d, skips %0d",
             sb.started, sb.cooled, sb.idled, sb.moves, sb.flips, sb.skips);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/asbs_pkg.sv
hdl/alarm_servo_buzzer_sequencer_top.sv
tb/asbs_tb_pkg.sv
tb/tb.sv
